// ===== design/token_passing_mac_core_assert.svh =====
// Assertion macros used by the checker file tpm_checker.sv.
`ifndef TOKEN_PASSING_MAC_CORE_ASSERT_SVH
`define TOKEN_PASSING_MAC_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants of the token passing access controller.
// ----------------------------------------------------------------------------
package tpm_pkg;
    localparam int MaxStations = 16;
    localparam int IdxW = $clog2(MaxStations);
    localparam int CntW = $clog2(MaxStations + 1);

    localparam logic [2:0] MODE_PACKET = 3'd0;
    localparam logic [2:0] MODE_TICK   = 3'd1;
    localparam logic [2:0] MODE_ARB    = 3'd2;
    localparam logic [2:0] MODE_OFFER  = 3'd3;
    localparam logic [2:0] MODE_EMPTY  = 3'd4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_BACK  = 2'd2;
    localparam logic [1:0] KIND_TOKEN = 2'd3;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_FRAME      = 3'd1;
    localparam logic [2:0] ACT_REGISTER   = 3'd2;
    localparam logic [2:0] ACT_GIVE_BACK  = 3'd3;
    localparam logic [2:0] ACT_GIVE_TOKEN = 3'd4;
    localparam logic [2:0] ACT_DELIVER    = 3'd5;
    localparam logic [2:0] ACT_ERROR      = 3'd6;

    localparam logic [2:0] REG_OWN_ID   = 3'd0;
    localparam logic [2:0] REG_MASTER   = 3'd1;
    localparam logic [2:0] REG_CHANCE   = 3'd2;
    localparam logic [2:0] REG_OVERHEAD = 3'd3;
    localparam logic [2:0] REG_BUDGET   = 3'd4;
    localparam logic [2:0] REG_INTERVAL = 3'd5;
    localparam logic [2:0] REG_TIMEOUT  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_EXEC, S_OUT1, S_OUT2
    } t_state;

    typedef struct packed {
        logic load;    // capture input item, reset search
        logic step;    // advance search one entry
        logic exec;    // apply state update, build results
    } t_cmd;

    typedef struct packed {
        logic search_done;
    } t_status;
endpackage

// ===== design/tpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpm_ctrl
// Sequencer: capture, table search, execute, then present results.
// ----------------------------------------------------------------------------
module tpm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_ready,
    input  logic             i_two,
    input  tpm_pkg::t_status i_status,
    output logic             o_ready,
    output logic             o_out_valid,
    output logic             o_second,
    output tpm_pkg::t_cmd    o_cmd
);
    import tpm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SEARCH;
            S_SEARCH: if (i_status.search_done) n_state = S_EXEC;
            S_EXEC:   n_state = S_OUT1;
            S_OUT1:   if (i_out_ready) n_state = i_two ? S_OUT2 : S_IDLE;
            S_OUT2:   if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT1) || (r_state == S_OUT2);
        o_second    = (r_state == S_OUT2);
        o_cmd.load  = (r_state == S_IDLE) && i_valid;
        o_cmd.step  = (r_state == S_SEARCH) && !i_status.search_done;
        o_cmd.exec  = (r_state == S_EXEC);
    end
endmodule

// ===== design/tpm_dp.sv =====
// ----------------------------------------------------------------------------
// tpm_dp
// Datapath: registers, station table, search unit and result build.
// ----------------------------------------------------------------------------
module tpm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpm_pkg::t_cmd    i_cmd,
    output tpm_pkg::t_status o_status,
    input  logic [2:0]       i_mode,
    input  logic [1:0]       i_pkt_kind,
    input  logic [7:0]       i_pkt_station,
    input  logic [7:0]       i_frame_length,
    input  logic             i_frame_is_last,
    input  logic [2:0]       i_penalty_draw,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output logic [31:0]      o_cfg_rdata,
    input  logic             i_second,
    output logic             o_two,
    output logic [2:0]       o_action,
    output logic [7:0]       o_target_station,
    output logic             o_frame_taken,
    output logic             o_last_result
);
    import tpm_pkg::*;

    // Configuration.
    logic [7:0]  r_own_id, r_chance;
    logic        r_master;
    logic [5:0]  r_overhead;
    logic [9:0]  r_budget;
    logic [7:0]  r_interval;
    logic [15:0] r_timeout;

    // Table storage, undefined until written.
    logic [7:0]  r_ids [MaxStations];
    logic [15:0] r_tmo [MaxStations];

    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] r_cur;
    logic            r_token_free, r_holds, r_registered;
    logic [7:0]      r_grants;
    logic [15:0]     r_ticks;
    logic [9:0]      r_bytes;
    logic [2:0]      r_backoff;

    // Captured item.
    logic [2:0] r_mode;
    logic [1:0] r_kind;
    logic [7:0] r_sta, r_len;
    logic       r_last;
    logic [2:0] r_draw;

    // Search state.
    logic [CntW-1:0] r_sidx;
    logic            r_found;
    logic [IdxW-1:0] r_fidx;

    // Results.
    logic [2:0] r_act0, r_act1;
    logic [7:0] r_tgt0, r_tgt1;
    logic       r_tk0, r_two;
    logic [2:0] n_act0;
    logic [7:0] n_tgt0;
    logic       n_tk0, n_two;

    logic [IdxW-1:0] w_nxt_idx;
    logic [CntW-1:0] w_inc;
    logic [10:0]     w_sum;
    logic            w_tmo_out;

    assign o_status.search_done = (r_sidx >= r_count) || r_found;
    assign w_inc     = {1'b0, r_cur} + CntW'(1);
    assign w_nxt_idx = (w_inc >= r_count) ? '0 : w_inc[IdxW-1:0];
    assign w_sum     = {1'b0, r_bytes} + {3'b0, r_len} + {5'b0, r_overhead};
    assign w_tmo_out = r_ticks > r_timeout;

    always_comb begin
        o_cfg_rdata = '0;
        case (i_cfg_idx)
            REG_OWN_ID:   o_cfg_rdata = {24'd0, r_own_id};
            REG_MASTER:   o_cfg_rdata = {31'd0, r_master};
            REG_CHANCE:   o_cfg_rdata = {24'd0, r_chance};
            REG_OVERHEAD: o_cfg_rdata = {26'd0, r_overhead};
            REG_BUDGET:   o_cfg_rdata = {22'd0, r_budget};
            REG_INTERVAL: o_cfg_rdata = {24'd0, r_interval};
            REG_TIMEOUT:  o_cfg_rdata = {16'd0, r_timeout};
            default:      o_cfg_rdata = '0;
        endcase
    end

    // Control and configuration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0; r_master <= 1'b0; r_chance <= 8'd255;
            r_overhead <= 6'd6; r_budget <= 10'd30; r_interval <= 8'd20;
            r_timeout <= 16'd500;
            r_count <= '0; r_cur <= '0; r_token_free <= 1'b1; r_holds <= 1'b0;
            r_registered <= 1'b0; r_grants <= '0; r_ticks <= '0;
            r_bytes <= '0; r_backoff <= '0; r_sidx <= '0; r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OWN_ID: r_own_id <= i_cfg_data[7:0];
                    REG_MASTER: begin
                        if (i_cfg_data[0] && !r_master) begin
                            r_count <= CntW'(1); r_cur <= '0; r_registered <= 1'b1;
                        end
                        r_master <= i_cfg_data[0];
                    end
                    REG_CHANCE:   r_chance <= i_cfg_data[7:0];
                    REG_OVERHEAD: r_overhead <= i_cfg_data[5:0];
                    REG_BUDGET:   r_budget <= i_cfg_data[9:0];
                    REG_INTERVAL: r_interval <= i_cfg_data[7:0];
                    REG_TIMEOUT:  r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_sidx <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.step) begin
                if (r_ids[r_sidx[IdxW-1:0]] == r_sta) r_found <= 1'b1;
                else r_sidx <= r_sidx + 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_mode)
                    MODE_PACKET: begin
                        if (r_kind == KIND_DATA) begin
                        end else if (r_master) begin
                            if (r_kind == KIND_REG && !r_found
                                && r_count < CntW'(MaxStations))
                                r_count <= r_count + 1'b1;
                            if (r_kind == KIND_BACK) r_token_free <= 1'b1;
                        end else if (r_kind == KIND_TOKEN) begin
                            if (r_sta == r_own_id) begin
                                r_holds <= 1'b1; r_bytes <= '0;
                                r_backoff <= '0; r_registered <= 1'b1;
                            end else if (!r_registered && r_sta == r_chance) begin
                                if (r_backoff == 3'd0)
                                    r_backoff <= (r_draw > 3'd4) ? 3'd4 : r_draw;
                                else
                                    r_backoff <= r_backoff - 1'b1;
                            end
                        end
                    end
                    MODE_TICK: if (r_ticks != 16'hFFFF) r_ticks <= r_ticks + 1'b1;
                    MODE_ARB: begin
                        if (r_master && r_count != '0 && (r_token_free || w_tmo_out)) begin
                            r_token_free <= 1'b0;
                            r_ticks <= '0;
                            if (r_grants >= r_interval) begin
                                r_grants <= '0;
                            end else begin
                                r_grants <= r_grants + 1'b1;
                                r_cur <= w_nxt_idx;
                                if (r_ids[w_nxt_idx] == r_own_id) begin
                                    r_holds <= 1'b1; r_bytes <= '0;
                                    r_backoff <= '0; r_registered <= 1'b1;
                                end
                            end
                        end
                    end
                    MODE_OFFER: begin
                        if (r_holds) begin
                            if (w_sum <= {1'b0, r_budget}) begin
                                // A client that sends its last frame starts the next
                                // hold from zero; otherwise the count accumulates.
                                if (r_last && !r_master) r_bytes <= '0;
                                else r_bytes <= w_sum[9:0];
                                if (r_last) begin
                                    r_holds <= 1'b0;
                                    if (r_master) r_token_free <= 1'b1;
                                end
                            end else begin
                                r_holds <= 1'b0;
                                if (r_master) r_token_free <= 1'b1;
                                else r_bytes <= '0;
                            end
                        end
                    end
                    MODE_EMPTY: begin
                        if (r_holds) begin
                            r_holds <= 1'b0;
                            if (r_master) r_token_free <= 1'b1;
                            else r_bytes <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Table writes and payload capture.
    always_ff @(posedge i_clk) begin
        if (i_cfg_we && i_cfg_idx == REG_OWN_ID && r_master && r_count != '0)
            r_ids[0] <= i_cfg_data[7:0];
        if (i_cfg_we && i_cfg_idx == REG_MASTER && i_cfg_data[0] && !r_master) begin
            r_ids[0] <= r_own_id;
            r_tmo[0] <= '0;
        end
        if (i_cmd.load) begin
            r_mode <= i_mode; r_kind <= i_pkt_kind; r_sta <= i_pkt_station;
            r_len <= i_frame_length; r_last <= i_frame_is_last;
            r_draw <= i_penalty_draw;
        end
        if (i_cmd.exec && r_master) begin
            if (r_mode == MODE_PACKET && r_kind == KIND_REG && !r_found
                && r_count < CntW'(MaxStations)) begin
                r_ids[r_count[IdxW-1:0]] <= r_sta;
                r_tmo[r_count[IdxW-1:0]] <= '0;
            end
            if (r_mode == MODE_PACKET && r_kind == KIND_BACK && r_found)
                r_tmo[r_fidx] <= '0;
            if (r_mode == MODE_ARB && r_count != '0 && w_tmo_out
                && {1'b0, r_cur} < r_count && r_tmo[r_cur] != 16'hFFFF)
                r_tmo[r_cur] <= r_tmo[r_cur] + 1'b1;
        end
    end

    assign r_fidx = r_sidx[IdxW-1:0];

    // Result build.
    always_comb begin
        n_act0 = ACT_NONE; n_tgt0 = '0; n_tk0 = 1'b0; n_two = 1'b0;
        case (r_mode)
            MODE_PACKET: begin
                if (r_kind == KIND_DATA) begin
                    n_act0 = ACT_DELIVER; n_tgt0 = r_sta;
                end else if (r_master) begin
                    if (r_kind == KIND_BACK && !r_found) begin
                        n_act0 = ACT_ERROR; n_tgt0 = r_sta;
                    end
                end else if (r_kind == KIND_TOKEN && r_sta != r_own_id
                             && !r_registered && r_sta == r_chance
                             && r_backoff == 3'd0) begin
                    n_act0 = ACT_REGISTER; n_tgt0 = r_own_id;
                end
            end
            MODE_ARB: begin
                if (r_master) begin
                    if (r_count == '0) begin
                        n_act0 = ACT_ERROR;
                    end else if (r_token_free || w_tmo_out) begin
                        if (r_grants >= r_interval) begin
                            n_act0 = ACT_GIVE_TOKEN; n_tgt0 = r_chance;
                        end else if (r_ids[w_nxt_idx] != r_own_id) begin
                            n_act0 = ACT_GIVE_TOKEN; n_tgt0 = r_ids[w_nxt_idx];
                        end
                    end
                end
            end
            MODE_OFFER: begin
                if (r_holds) begin
                    if (w_sum <= {1'b0, r_budget}) begin
                        n_act0 = ACT_FRAME; n_tgt0 = r_own_id; n_tk0 = 1'b1;
                        n_two = r_last && !r_master;
                    end else if (!r_master) begin
                        n_act0 = ACT_GIVE_BACK; n_tgt0 = r_own_id;
                    end
                end
            end
            MODE_EMPTY: begin
                if (r_holds && !r_master) begin
                    n_act0 = ACT_GIVE_BACK; n_tgt0 = r_own_id;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_act0 <= n_act0; r_tgt0 <= n_tgt0; r_tk0 <= n_tk0; r_two <= n_two;
            r_act1 <= ACT_GIVE_BACK; r_tgt1 <= r_own_id;
        end
    end

    assign o_two            = r_two;
    assign o_action         = i_second ? r_act1 : r_act0;
    assign o_target_station = i_second ? r_tgt1 : r_tgt0;
    assign o_frame_taken    = i_second ? 1'b0 : r_tk0;
    assign o_last_result    = i_second || !r_two;
endmodule

// ===== design/token_passing_mac_core.sv =====
// Flow: an accepted item goes through a sequential search of the station table, one
// entry at a time and up to 16 entries, then an execute state, and its first result
// is then presented and held until taken. One item at a time: a new item is accepted
// only after its last result is taken; a second result, when there is one, follows
// in the cycle after the first is taken.
// Reset is synchronous, active low, and clears all control and configuration state.
// The station table holds no reset; entries are read only after being written.
// ----------------------------------------------------------------------------
// token_passing_mac_core
// Token passing medium access controller with APB configuration port.
// ----------------------------------------------------------------------------
module token_passing_mac_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_pkt_kind,
    input  logic [7:0]  i_pkt_station,
    input  logic [7:0]  i_frame_length,
    input  logic        i_frame_is_last,
    input  logic [2:0]  i_penalty_draw,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_target_station,
    output logic        o_frame_taken,
    output logic        o_last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_two, w_second, w_cfg_we;

    // Registers sit at word addresses; the write lands in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    // The controller sequences each transaction: capture, search, execute, output.
    tpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_ready(i_ready),
        .i_two      (w_two),
        .i_status   (w_status),
        .o_ready    (o_ready),
        .o_out_valid(o_valid),
        .o_second   (w_second),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the table and all state the model updates.
    tpm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_mode          (i_mode),
        .i_pkt_kind      (i_pkt_kind),
        .i_pkt_station   (i_pkt_station),
        .i_frame_length  (i_frame_length),
        .i_frame_is_last (i_frame_is_last),
        .i_penalty_draw  (i_penalty_draw),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_idx       (paddr[4:2]),
        .i_cfg_data      (pwdata[15:0]),
        .o_cfg_rdata     (prdata),
        .i_second        (w_second),
        .o_two           (w_two),
        .o_action        (o_action),
        .o_target_station(o_target_station),
        .o_frame_taken   (o_frame_taken),
        .o_last_result   (o_last_result)
    );
endmodule

// ===== design/tpm_checker.sv =====
// ----------------------------------------------------------------------------
// tpm_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "token_passing_mac_core_assert.svh"
module tpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_action,
    input logic       o_frame_taken,
    input logic       o_last_result
);
    import tpm_pkg::*;
    `TPM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `TPM_ASSERT_IMP(a_taken_frame, i_clk, i_rst_n, o_valid && o_frame_taken, o_action == ACT_FRAME)
    `TPM_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_last_result, o_ready)
    `TPM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_action))
endmodule

bind token_passing_mac_core tpm_checker u_tpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_action     (o_action),
    .o_frame_taken(o_frame_taken),
    .o_last_result(o_last_result)
);

// ===== bench/token_passing_mac_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_passing_mac_checker
// Watches the item, result and register ports of the access controller, keeps
// its own model of the station table and token state, and compares every
// result transaction field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module token_passing_mac_checker
    import tpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_pkt_kind,
    input  logic [7:0]  i_pkt_station,
    input  logic [7:0]  i_frame_length,
    input  logic        i_frame_is_last,
    input  logic [2:0]  i_penalty_draw,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_target_station,
    input  logic        i_frame_taken,
    input  logic        i_last_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results_seen
);
    localparam int ExpDepth = 8;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] target;
        logic       taken;
        logic       last;
    } mac_result_t;

    // Ring of expected results, oldest at exp_head.
    mac_result_t exp_buf [ExpDepth];
    int          exp_head;
    int          exp_count;
    // Results of the item being predicted; at most two.
    mac_result_t step_buf [2];
    int          step_n;

    // Configuration copy.
    logic [7:0]  own_id, chance_id, interval;
    logic        master;
    logic [5:0]  overhead;
    logic [9:0]  budget;
    logic [15:0] timeout_lim;

    // Token and table state.
    logic [7:0]  table_ids [MaxStations];
    logic [15:0] table_touts [MaxStations];
    int          table_cnt;
    int          cur_idx;
    logic        token_free, holding, registered;
    logic [7:0]  grants;
    logic [15:0] ticks;
    int          sent_bytes;
    logic [2:0]  backoff;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    task automatic emit_result(input logic [2:0] act, input logic [7:0] tgt,
                               input logic taken);
        mac_result_t r;
        r.action = act;
        r.target = tgt;
        r.taken  = taken;
        r.last   = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endtask

    function automatic int find_station(input logic [7:0] id);
        for (int i = 0; i < table_cnt; i++)
            if (table_ids[i] == id) return i;
        return -1;
    endfunction

    task automatic take_token();
        holding = 1'b1;
        sent_bytes = 0;
        backoff = '0;
        registered = 1'b1;
    endtask

    task automatic return_token();
        holding = 1'b0;
        if (master) begin
            token_free = 1'b1;
        end else begin
            sent_bytes = 0;
            emit_result(ACT_GIVE_BACK, own_id, 1'b0);
        end
    endtask

    task automatic reset_model();
        own_id = 8'd0; master = 1'b0; chance_id = 8'd255; overhead = 6'd6;
        budget = 10'd30; interval = 8'd20; timeout_lim = 16'd500;
        table_cnt = 0; cur_idx = 0; token_free = 1'b1; grants = '0; ticks = '0;
        holding = 1'b0; registered = 1'b0; sent_bytes = 0; backoff = '0;
        exp_head = 0; exp_count = 0; step_n = 0;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] v);
        case (idx)
            REG_OWN_ID: begin
                own_id = v[7:0];
                if (master && table_cnt > 0) table_ids[0] = own_id;
            end
            REG_MASTER: begin
                if (v[0] && !master) begin
                    table_ids[0] = own_id;
                    table_touts[0] = '0;
                    table_cnt = 1;
                    cur_idx = 0;
                    registered = 1'b1;
                end
                master = v[0];
            end
            REG_CHANCE:   chance_id = v[7:0];
            REG_OVERHEAD: overhead = v[5:0];
            REG_BUDGET:   budget = v[9:0];
            REG_INTERVAL: interval = v[7:0];
            REG_TIMEOUT:  timeout_lim = v;
            default: ;
        endcase
    endtask

    task automatic handle_packet(input logic [1:0] kind, input logic [7:0] sta,
                                 input logic [2:0] draw);
        int idx;
        if (kind == KIND_DATA) begin
            emit_result(ACT_DELIVER, sta, 1'b0);
            return;
        end
        if (master) begin
            if (kind == KIND_REG) begin
                // A full table silently drops the newcomer.
                if (find_station(sta) < 0 && table_cnt < MaxStations) begin
                    table_ids[table_cnt] = sta;
                    table_touts[table_cnt] = '0;
                    table_cnt++;
                end
            end else if (kind == KIND_BACK) begin
                token_free = 1'b1;
                idx = find_station(sta);
                if (idx < 0) begin
                    emit_result(ACT_ERROR, sta, 1'b0);
                    return;
                end
                table_touts[idx] = '0;
            end
            emit_result(ACT_NONE, 8'd0, 1'b0);
            return;
        end
        if (kind == KIND_TOKEN) begin
            if (sta == own_id) begin
                take_token();
            end else if (!registered && sta == chance_id) begin
                if (backoff == 0) begin
                    backoff = (draw > 3'd4) ? 3'd4 : draw;
                    emit_result(ACT_REGISTER, own_id, 1'b0);
                    return;
                end
                backoff--;
            end
        end
        emit_result(ACT_NONE, 8'd0, 1'b0);
    endtask

    task automatic handle_arbitration();
        logic timed_out;
        if (!master) begin
            emit_result(ACT_NONE, 8'd0, 1'b0);
            return;
        end
        if (table_cnt == 0) begin
            emit_result(ACT_ERROR, 8'd0, 1'b0);
            return;
        end
        timed_out = ticks > timeout_lim;
        if (timed_out && cur_idx < table_cnt && table_touts[cur_idx] != 16'hFFFF)
            table_touts[cur_idx]++;
        if (!(token_free || timed_out)) begin
            emit_result(ACT_NONE, 8'd0, 1'b0);
            return;
        end
        token_free = 1'b0;
        ticks = '0;
        if (grants >= interval) begin
            // Registration chance replaces a regular grant.
            grants = '0;
            emit_result(ACT_GIVE_TOKEN, chance_id, 1'b0);
            return;
        end
        grants++;
        cur_idx = (cur_idx + 1) % table_cnt;
        if (table_ids[cur_idx] == own_id) begin
            take_token();
            emit_result(ACT_NONE, 8'd0, 1'b0);
        end else begin
            emit_result(ACT_GIVE_TOKEN, table_ids[cur_idx], 1'b0);
        end
    endtask

    task automatic handle_offer(input logic [7:0] len, input logic last);
        int cost;
        if (!holding) begin
            emit_result(ACT_NONE, 8'd0, 1'b0);
            return;
        end
        cost = int'(len) + int'(overhead);
        if (sent_bytes + cost <= int'(budget)) begin
            sent_bytes = (sent_bytes + cost) & 'h3FF;
            emit_result(ACT_FRAME, own_id, 1'b1);
            if (last) return_token();
        end else begin
            return_token();
        end
    endtask

    task automatic predict_item();
        step_n = 0;
        case (i_mode)
            MODE_PACKET: handle_packet(i_pkt_kind, i_pkt_station, i_penalty_draw);
            MODE_TICK:   if (ticks != 16'hFFFF) ticks++;
            MODE_ARB:    handle_arbitration();
            MODE_OFFER:  handle_offer(i_frame_length, i_frame_is_last);
            MODE_EMPTY:  if (holding) return_token();
            default: ;
        endcase
        if (step_n == 0) emit_result(ACT_NONE, 8'd0, 1'b0);
        step_buf[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) begin
            exp_buf[(exp_head + exp_count) % ExpDepth] = step_buf[i];
            exp_count++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_results_seen = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        mac_result_t want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (exp_count == 0) begin
                    $display("%0t: result transaction with nothing expected", $time);
                    o_errors++;
                end else begin
                    want = exp_buf[exp_head];
                    exp_head = (exp_head + 1) % ExpDepth;
                    exp_count--;
                    if (i_action !== want.action)
                        report_mismatch("action", int'(i_action), int'(want.action));
                    if (i_target_station !== want.target)
                        report_mismatch("target_station", int'(i_target_station),
                                        int'(want.target));
                    if (i_frame_taken !== want.taken)
                        report_mismatch("frame_taken", int'(i_frame_taken), int'(want.taken));
                    if (i_last_result !== want.last)
                        report_mismatch("last_result", int'(i_last_result), int'(want.last));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr[4:2], i_pwdata[15:0]);
            if (i_in_valid && i_in_ready) predict_item();
        end
        o_pending <= exp_count;
    end
endmodule

// ===== bench/tb_token_passing_mac_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_token_passing_mac_core
// Drives the access controller through master and client configurations with
// directed and randomized packet, tick, arbitration and frame transactions,
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_token_passing_mac_core;
    import tpm_pkg::*;

    localparam int PhaseCount = 7;
    localparam int ItemsPerPhase = 148;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = '0;
    logic [1:0]  i_pkt_kind = '0;
    logic [7:0]  i_pkt_station = '0;
    logic [7:0]  i_frame_length = '0;
    logic        i_frame_is_last = 1'b0;
    logic [2:0]  i_penalty_draw = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_action;
    logic [7:0]  o_target_station;
    logic        o_frame_taken;
    logic        o_last_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, results_seen;
    int items_sent = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;       // when set, neither side inserts gaps
    bit hold_request = 1'b0;  // asks the receiver for one long hold-off

    // Station identifiers used by the current phase; the first is our own.
    logic [7:0] station_pool [24];
    logic [7:0] own_id_now, chance_id_now;
    bit         master_now;

    always #5 i_clk = ~i_clk;

    token_passing_mac_core dut (.*);

    token_passing_mac_checker checker_inst (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_mode, .i_pkt_kind, .i_pkt_station, .i_frame_length,
        .i_frame_is_last, .i_penalty_draw,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_action(o_action), .i_target_station(o_target_station),
        .i_frame_taken(o_frame_taken), .i_last_result(o_last_result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_results_seen(results_seen)
    );

    // The watchdog restarts whenever any transaction completes.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("tb_token_passing_mac_core NOT OK");
            $finish;
        end
    end

    // Result side: random stalls per transaction, plus one long hold-off on request.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Register write with setup and access phases; called at a falling edge, returns at one.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Offers one item transaction; called at a falling edge, returns at one.
    task automatic send_item(input logic [2:0] mode, input logic [1:0] kind,
                             input logic [7:0] sta, input logic [7:0] len,
                             input logic last, input logic [2:0] draw);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode = mode; i_pkt_kind = kind; i_pkt_station = sta;
        i_frame_length = len; i_frame_is_last = last; i_penalty_draw = draw;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] own, input bit master,
                             input logic [7:0] chance, input logic [5:0] ovh,
                             input logic [9:0] budget, input logic [7:0] intv,
                             input logic [15:0] tmo);
        write_reg(REG_OWN_ID, ($urandom & 32'hFFFF_FF00) | {24'd0, own});
        write_reg(REG_CHANCE, {24'd0, chance});
        write_reg(REG_OVERHEAD, {26'd0, ovh});
        write_reg(REG_BUDGET, {22'd0, budget});
        write_reg(REG_INTERVAL, {24'd0, intv});
        write_reg(REG_TIMEOUT, {16'd0, tmo});
        write_reg(REG_MASTER, {31'd0, master});
        own_id_now = own; chance_id_now = chance; master_now = master;
        station_pool[0] = own;
        for (int i = 1; i < 24; i++) station_pool[i] = 8'($urandom);
    endtask

    // One random item shaped by the role: masters mostly see registrations, passes,
    // give-backs, ticks and offers; clients mostly see token grants, chances and offers.
    task automatic random_item();
        int roll;
        logic [2:0] mode;
        logic [1:0] kind;
        logic [7:0] sta;
        logic [7:0] len;
        roll = $urandom_range(0, 99);
        kind = 2'($urandom);
        sta = station_pool[$urandom_range(0, 23)];
        mode = MODE_PACKET;
        if (roll < 3) begin
            mode = 3'($urandom_range(5, 7));
        end else if (roll < 8) begin
            sta = 8'($urandom);
        end else if (master_now) begin
            if (roll < 25)      kind = KIND_REG;
            else if (roll < 45) mode = MODE_ARB;
            else if (roll < 60) kind = KIND_BACK;
            else if (roll < 72) mode = MODE_TICK;
            else if (roll < 90) mode = MODE_OFFER;
            else                mode = MODE_EMPTY;
        end else begin
            if (roll < 25)      begin kind = KIND_TOKEN; sta = own_id_now; end
            else if (roll < 45) begin kind = KIND_TOKEN; sta = chance_id_now; end
            else if (roll < 75) mode = MODE_OFFER;
            else if (roll < 85) mode = MODE_EMPTY;
            else if (roll < 92) mode = MODE_TICK;
            else                mode = MODE_ARB;
        end
        len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        send_item(mode, kind, sta, len, $urandom_range(0, 3) == 0, 3'($urandom));
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: client taking the token, chance answers with backoff,
        // budget overrun, then master registration, full table and arbitration.
        configure(8'd0, 1'b0, 8'd255, 6'd0, 10'd20, 8'd0, 16'd0);
        send_item(MODE_PACKET, KIND_DATA, 8'd255, 8'd0, 1'b0, 3'd0);
        send_item(MODE_PACKET, KIND_TOKEN, 8'd255, 8'd0, 1'b0, 3'd7);
        send_item(MODE_PACKET, KIND_TOKEN, 8'd255, 8'd0, 1'b0, 3'd0);
        send_item(MODE_PACKET, KIND_TOKEN, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(MODE_OFFER, KIND_DATA, 8'd0, 8'd10, 1'b0, 3'd0);
        send_item(MODE_OFFER, KIND_DATA, 8'd0, 8'd255, 1'b1, 3'd0);
        send_item(MODE_PACKET, KIND_TOKEN, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(MODE_OFFER, KIND_DATA, 8'd0, 8'd5, 1'b1, 3'd0);
        send_item(MODE_EMPTY, KIND_DATA, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(MODE_ARB, KIND_DATA, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(3'd7, KIND_TOKEN, 8'hFF, 8'hFF, 1'b1, 3'd7);
        drain();
        configure(8'd255, 1'b1, 8'd0, 6'd63, 10'd1023, 8'd0, 16'd0);
        for (int i = 1; i <= 17; i++)
            send_item(MODE_PACKET, KIND_REG, 8'(i), 8'd0, 1'b0, 3'd0);
        send_item(MODE_PACKET, KIND_BACK, 8'd200, 8'd0, 1'b0, 3'd0);
        send_item(MODE_TICK, KIND_DATA, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(MODE_ARB, KIND_DATA, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(MODE_ARB, KIND_DATA, 8'd0, 8'd0, 1'b0, 3'd0);
        drain();

        // Random phases over a spread of settings, extremes included.
        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0: configure(8'($urandom), 1'b1, 8'd255, 6'd6, 10'd30, 8'd3, 16'd2);
                1: configure(8'($urandom), 1'b0, 8'($urandom), 6'd0, 10'd1023, 8'd20,
                             16'd500);
                2: configure(8'd255, 1'b1, 8'd0, 6'd63, 10'd0, 8'd255, 16'd65535);
                3: configure(8'd0, 1'b0, 8'd255, 6'($urandom), 10'($urandom),
                             8'($urandom), 16'($urandom));
                4: configure(8'($urandom), 1'b1, 8'($urandom), 6'd2, 10'd40, 8'd0, 16'd0);
                5: configure(8'($urandom), 1'b0, 8'($urandom), 6'd1, 10'd25, 8'd1, 16'd1);
                default: configure(8'($urandom), 1'b1, 8'd255, 6'($urandom),
                                   10'($urandom), 8'd4, 16'd5);
            endcase
            no_idle = (p % 3 == 2);
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (p == 1 && n == 20) hold_request = 1'b1;
                random_item();
            end
            drain();
        end

        $display("Sent %0d item transactions over %0d register settings in both roles;",
                 items_sent, PhaseCount + 2);
        $display("checked %0d result transactions, including one long output hold-off.",
                 results_seen);
        if (errors == 0)
            $display("tb_token_passing_mac_core OK");
        else
            $display("tb_token_passing_mac_core NOT OK");
        $finish;
    end
endmodule

// ===== token_passing_mac_core.f =====
+incdir+design
design/tpm_pkg.sv
design/tpm_ctrl.sv
design/tpm_dp.sv
design/token_passing_mac_core.sv
design/tpm_checker.sv
bench/token_passing_mac_checker.sv
bench/tb_token_passing_mac_core.sv
